// ----- hdl/rdbe_pkg.sv -----
// Package with the fixed-point constants and pipeline sizes of the rough diffuse BRDF evaluator.
package rdbe_pkg;

    localparam int DIV_STEPS = 32;
    localparam int AB_STEPS = 14;

    localparam logic [32:0] C033_Q30 = 33'd354334802;
    localparam logic [32:0] C009_Q30 = 33'd96636764;
    localparam logic [13:0] C045_Q15 = 14'd14746;
    localparam logic [13:0] INVPI_Q15 = 14'd10430;
    localparam logic [16:0] ONE_Q15 = 17'd32768;
    localparam logic [14:0] HALF_Q15 = 15'd16384;
    localparam logic [14:0] THR_RESET = 15'd33;

endpackage

// ----- hdl/rough_diffuse_brdf_eval.sv -----
// Top level of the pipelined improved Oren-Nayar rough diffuse BRDF evaluator.
// Throughput is one beat per cycle while the output is not stalled; the three divisions
// run one quotient bit per stage, A and B only in their first AB_STEPS division stages.
// A stall on the output freezes the whole pipeline and no beat is lost or repeated.
// Reset clears all valid bits at once and sets the grazing threshold to 33.
module rough_diffuse_brdf_eval
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] out_dir_x,
    input  logic [15:0] out_dir_y,
    input  logic [15:0] out_dir_z,
    input  logic [15:0] in_dir_x,
    input  logic [15:0] in_dir_y,
    input  logic [15:0] in_dir_z,
    input  logic [15:0] roughness,
    input  logic [15:0] color_red,
    input  logic [15:0] color_green,
    input  logic [15:0] color_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [15:0] refl_red,
    output logic [15:0] refl_green,
    output logic [15:0] refl_blue,
    output logic [15:0] direct_pdf,
    output logic [15:0] reverse_pdf,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data
);
    import rdbe_pkg::*;

    function automatic logic [15:0] round_sat(input logic [15:0] c, input logic [31:0] v);
        logic [48:0] sum;
        logic [33:0] rnd;
        sum = {1'b0, 48'(c) * 48'(v)} + 49'(HALF_Q15);
        rnd = sum[48:15];
        if (rnd > 34'(ONE_Q15))
            return ONE_Q15[15:0];
        return rnd[15:0];
    endfunction

    logic        adv;
    logic [14:0] thr_reg;

    assign cfg_ready = 1'b1;
    assign adv = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    // Stage 1: cosines, threshold test, products and pdfs.
    logic signed [16:0] nv_c, nl_c, thr_c;
    logic               ok_c;
    logic [29:0]        wsum_c, rsum_c;

    assign nv_c = $signed({out_dir_z[15], out_dir_z});
    assign nl_c = -$signed({in_dir_z[15], in_dir_z});
    assign thr_c = $signed({2'b00, thr_reg});
    assign ok_c = (nv_c > thr_c) && (nl_c > thr_c);
    assign wsum_c = 30'(nl_c[15:0]) * 30'(INVPI_Q15) + 30'(HALF_Q15);
    assign rsum_c = 30'(nv_c[15:0]) * 30'(INVPI_Q15) + 30'(HALF_Q15);

    logic               vld_s1_reg, ok_s1_reg;
    logic signed [31:0] px_s1_reg, py_s1_reg, pz_s1_reg;
    logic [31:0]        s2_s1_reg, nlnv_s1_reg;
    logic [15:0]        nl_s1_reg, nv_s1_reg;
    logic [13:0]        w_s1_reg, rp_s1_reg;
    logic [15:0]        cr_s1_reg, cg_s1_reg, cb_s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_s1_reg <= 1'b0;
        else if (adv)
            vld_s1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_s1_reg <= ok_c;
            px_s1_reg <= $signed(out_dir_x) * $signed(in_dir_x);
            py_s1_reg <= $signed(out_dir_y) * $signed(in_dir_y);
            pz_s1_reg <= $signed(out_dir_z) * $signed(in_dir_z);
            s2_s1_reg <= 32'(roughness) * 32'(roughness);
            nlnv_s1_reg <= 32'(nl_c[15:0]) * 32'(nv_c[15:0]);
            nl_s1_reg <= nl_c[15:0];
            nv_s1_reg <= nv_c[15:0];
            w_s1_reg <= wsum_c[28:15];
            rp_s1_reg <= rsum_c[28:15];
            cr_s1_reg <= color_red;
            cg_s1_reg <= color_green;
            cb_s1_reg <= color_blue;
        end
    end

    // Stage 2: s/t dividend, divisor and the A and B division setup.
    logic signed [33:0] dot_c, ldvn_c;
    logic [31:0]        ldv_c, spos_c;
    logic signed [34:0] s_c;
    logic [15:0]        m_c;
    logic [45:0]        bprod_c;

    assign dot_c = 34'(px_s1_reg) + 34'(py_s1_reg) + 34'(pz_s1_reg);
    assign ldvn_c = -dot_c;
    assign ldv_c = ldvn_c[33] ? 32'd0 : ldvn_c[31:0];
    assign s_c = $signed({3'b000, ldv_c}) - $signed({3'b000, nlnv_s1_reg});
    assign spos_c = (s_c > 35'sd0) ? s_c[31:0] : 32'd0;
    assign m_c = (nl_s1_reg > nv_s1_reg) ? nl_s1_reg : nv_s1_reg;
    assign bprod_c = 46'(C045_Q15) * 46'(s2_s1_reg);

    logic        vld_reg [0:DIV_STEPS];
    logic        ok_reg  [0:DIV_STEPS];
    logic [13:0] w_reg   [0:DIV_STEPS];
    logic [13:0] rp_reg  [0:DIV_STEPS];
    logic [15:0] cr_reg  [0:DIV_STEPS];
    logic [15:0] cg_reg  [0:DIV_STEPS];
    logic [15:0] cb_reg  [0:DIV_STEPS];
    logic [32:0] a_rem_reg [0:DIV_STEPS];
    logic [32:0] a_den_reg [0:DIV_STEPS];
    logic [13:0] a_sh_reg  [0:DIV_STEPS];
    logic [32:0] b_rem_reg [0:DIV_STEPS];
    logic [32:0] b_den_reg [0:DIV_STEPS];
    logic [13:0] b_sh_reg  [0:DIV_STEPS];
    logic [15:0] t_rem_reg [0:DIV_STEPS];
    logic [15:0] t_den_reg [0:DIV_STEPS];
    logic [31:0] t_sh_reg  [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= vld_s1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_reg[0] <= ok_s1_reg;
            w_reg[0] <= w_s1_reg;
            rp_reg[0] <= rp_s1_reg;
            cr_reg[0] <= cr_s1_reg;
            cg_reg[0] <= cg_s1_reg;
            cb_reg[0] <= cb_s1_reg;
            a_rem_reg[0] <= {1'b0, s2_s1_reg};
            a_den_reg[0] <= C033_Q30 + 33'(s2_s1_reg);
            a_sh_reg[0] <= '0;
            b_rem_reg[0] <= {1'b0, bprod_c[45:14]};
            b_den_reg[0] <= C009_Q30 + 33'(s2_s1_reg);
            b_sh_reg[0] <= bprod_c[13:0];
            t_rem_reg[0] <= '0;
            t_den_reg[0] <= m_c;
            t_sh_reg[0] <= spos_c;
        end
    end

    // Division stages: one restoring quotient bit per stage, for A and B only in the first AB_STEPS stages.
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [33:0] a_trial, b_trial;
        logic [33:0] a_diff, b_diff;
        logic        a_ge, b_ge;
        logic [16:0] t_trial, t_diff;
        logic        t_ge;

        assign a_trial = {a_rem_reg[k], a_sh_reg[k][13]};
        assign a_ge = a_trial >= {1'b0, a_den_reg[k]};
        assign a_diff = a_trial - {1'b0, a_den_reg[k]};
        assign b_trial = {b_rem_reg[k], b_sh_reg[k][13]};
        assign b_ge = b_trial >= {1'b0, b_den_reg[k]};
        assign b_diff = b_trial - {1'b0, b_den_reg[k]};
        assign t_trial = {t_rem_reg[k], t_sh_reg[k][31]};
        assign t_ge = t_trial >= {1'b0, t_den_reg[k]};
        assign t_diff = t_trial - {1'b0, t_den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k + 1] <= 1'b0;
            else if (adv)
                vld_reg[k + 1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ok_reg[k + 1] <= ok_reg[k];
                w_reg[k + 1] <= w_reg[k];
                rp_reg[k + 1] <= rp_reg[k];
                cr_reg[k + 1] <= cr_reg[k];
                cg_reg[k + 1] <= cg_reg[k];
                cb_reg[k + 1] <= cb_reg[k];
                a_den_reg[k + 1] <= a_den_reg[k];
                b_den_reg[k + 1] <= b_den_reg[k];
                t_den_reg[k + 1] <= t_den_reg[k];
                t_rem_reg[k + 1] <= t_ge ? t_diff[15:0] : t_trial[15:0];
                t_sh_reg[k + 1] <= {t_sh_reg[k][30:0], t_ge};
                if (k < AB_STEPS)
                begin
                    a_rem_reg[k + 1] <= a_ge ? a_diff[32:0] : a_trial[32:0];
                    a_sh_reg[k + 1] <= {a_sh_reg[k][12:0], a_ge};
                    b_rem_reg[k + 1] <= b_ge ? b_diff[32:0] : b_trial[32:0];
                    b_sh_reg[k + 1] <= {b_sh_reg[k][12:0], b_ge};
                end
                else
                begin
                    a_rem_reg[k + 1] <= a_rem_reg[k];
                    a_sh_reg[k + 1] <= a_sh_reg[k];
                    b_rem_reg[k + 1] <= b_rem_reg[k];
                    b_sh_reg[k + 1] <= b_sh_reg[k];
                end
            end
        end
    end

    // Tail: B*s/t, f, the weight v and the color products.
    logic        vld_f1_reg, vld_f2_reg, vld_f3_reg;
    logic        ok_f1_reg, ok_f2_reg, ok_f3_reg;
    logic [45:0] bst_f1_reg;
    logic [15:0] a_f1_reg;
    logic [31:0] f_f2_reg, v_f3_reg;
    logic [13:0] w_f1_reg, w_f2_reg, w_f3_reg, rp_f1_reg, rp_f2_reg, rp_f3_reg;
    logic [15:0] cr_f1_reg, cg_f1_reg, cb_f1_reg;
    logic [15:0] cr_f2_reg, cg_f2_reg, cb_f2_reg;
    logic [15:0] cr_f3_reg, cg_f3_reg, cb_f3_reg;
    logic [16:0] a_c;
    logic [46:0] vsum_c;

    assign a_c = ONE_Q15 - 17'(a_sh_reg[DIV_STEPS]);
    assign vsum_c = 47'(w_f2_reg) * 47'(f_f2_reg) + 47'(HALF_Q15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_f1_reg <= 1'b0;
            vld_f2_reg <= 1'b0;
            vld_f3_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            vld_f1_reg <= vld_reg[DIV_STEPS];
            vld_f2_reg <= vld_f1_reg;
            vld_f3_reg <= vld_f2_reg;
            out_valid <= vld_f3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_f1_reg <= ok_reg[DIV_STEPS];
            bst_f1_reg <= 46'(b_sh_reg[DIV_STEPS]) * 46'(t_sh_reg[DIV_STEPS]);
            a_f1_reg <= a_c[15:0];
            w_f1_reg <= w_reg[DIV_STEPS];
            rp_f1_reg <= rp_reg[DIV_STEPS];
            cr_f1_reg <= cr_reg[DIV_STEPS];
            cg_f1_reg <= cg_reg[DIV_STEPS];
            cb_f1_reg <= cb_reg[DIV_STEPS];

            ok_f2_reg <= ok_f1_reg;
            f_f2_reg <= 32'(a_f1_reg) + 32'(bst_f1_reg[45:15]);
            w_f2_reg <= w_f1_reg;
            rp_f2_reg <= rp_f1_reg;
            cr_f2_reg <= cr_f1_reg;
            cg_f2_reg <= cg_f1_reg;
            cb_f2_reg <= cb_f1_reg;

            ok_f3_reg <= ok_f2_reg;
            v_f3_reg <= vsum_c[46:15];
            w_f3_reg <= w_f2_reg;
            rp_f3_reg <= rp_f2_reg;
            cr_f3_reg <= cr_f2_reg;
            cg_f3_reg <= cg_f2_reg;
            cb_f3_reg <= cb_f2_reg;

            valid_res <= ok_f3_reg;
            refl_red <= ok_f3_reg ? round_sat(cr_f3_reg, v_f3_reg) : 16'd0;
            refl_green <= ok_f3_reg ? round_sat(cg_f3_reg, v_f3_reg) : 16'd0;
            refl_blue <= ok_f3_reg ? round_sat(cb_f3_reg, v_f3_reg) : 16'd0;
            direct_pdf <= ok_f3_reg ? 16'(w_f3_reg) : 16'd0;
            reverse_pdf <= ok_f3_reg ? 16'(rp_f3_reg) : 16'd0;
        end
    end

    a_grazing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (refl_red == 16'd0 && refl_green == 16'd0 &&
            refl_blue == 16'd0 && direct_pdf == 16'd0 && reverse_pdf == 16'd0))
        else $error("grazing beat carries nonzero result");

    a_refl_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (refl_red <= 16'd32768 && refl_green <= 16'd32768 &&
            refl_blue <= 16'd32768 && direct_pdf <= 16'd10430))
        else $error("result beyond saturation limit");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_f3_reg) && $stable(vld_reg[0]))
        else $error("pipeline moved while stalled");

endmodule

// ----- tb/sv/rdbe_checker.sv -----
// Checker that predicts and compares every result beat of the rough diffuse BRDF evaluator.
`timescale 1ns / 100ps
module rdbe_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] out_dir_x,
    input  logic [15:0] out_dir_y,
    input  logic [15:0] out_dir_z,
    input  logic [15:0] in_dir_x,
    input  logic [15:0] in_dir_y,
    input  logic [15:0] in_dir_z,
    input  logic [15:0] roughness,
    input  logic [15:0] color_red,
    input  logic [15:0] color_green,
    input  logic [15:0] color_blue,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        valid_res,
    input  logic [15:0] refl_red,
    input  logic [15:0] refl_green,
    input  logic [15:0] refl_blue,
    input  logic [15:0] direct_pdf,
    input  logic [15:0] reverse_pdf,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [14:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import rdbe_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] fwd;
        logic [15:0] rev;
    } shade_t;

    shade_t      shade_q[$];
    logic [14:0] grazing_thr;

    function automatic longint round_q15(longint a, longint b);
        return (a * b + longint'(HALF_Q15)) >>> 15;
    endfunction

    function automatic logic [15:0] clamp_q15(longint v);
        if (v < 0)
            return 16'd0;
        if (v > longint'(ONE_Q15))
            return 16'd32768;
        return v[15:0];
    endfunction

    function automatic shade_t shade_query(logic [14:0] thr);
        shade_t r;
        longint ox, oy, oz, ix, iy, iz, rough, nv, nl, s2, a, b, ldv, s, m, st, f, w, v;
        r = '0;
        ox = longint'($signed(out_dir_x));
        oy = longint'($signed(out_dir_y));
        oz = longint'($signed(out_dir_z));
        ix = longint'($signed(in_dir_x));
        iy = longint'($signed(in_dir_y));
        iz = longint'($signed(in_dir_z));
        rough = longint'(roughness);
        nv = oz;
        nl = -iz;
        if (!(nv > longint'(thr) && nl > longint'(thr)))
            return r;
        s2 = rough * rough;
        a = longint'(ONE_Q15) - (s2 * 16384) / (longint'(C033_Q30) + s2);
        b = (longint'(C045_Q15) * s2) / (longint'(C009_Q30) + s2);
        ldv = -(ox * ix + oy * iy + oz * iz);
        if (ldv < 0)
            ldv = 0;
        s = ldv - nl * nv;
        m = (nl > nv) ? nl : nv;
        st = (s > 0) ? s / m : 0;
        f = a + ((b * st) >>> 15);
        if (f < 0)
            f = 0;
        w = round_q15(nl, longint'(INVPI_Q15));
        v = round_q15(w, f);
        r.ok = 1'b1;
        r.red = clamp_q15(round_q15(longint'(color_red), v));
        r.green = clamp_q15(round_q15(longint'(color_green), v));
        r.blue = clamp_q15(round_q15(longint'(color_blue), v));
        r.fwd = clamp_q15(w);
        r.rev = clamp_q15(round_q15(nv, longint'(INVPI_Q15)));
        return r;
    endfunction

    task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        shade_t e;
        if (!rst_n)
        begin
            grazing_thr <= THR_RESET;
            fail_count = 0;
            shade_q.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                shade_q.push_back(shade_query(grazing_thr));
            if (out_valid && !out_stall)
            begin
                if (shade_q.size() == 0)
                begin
                    $error("result beat with no expected result");
                    fail_count++;
                end
                else
                begin
                    e = shade_q.pop_front();
                    compare_field("valid_res", 16'(e.ok), 16'(valid_res));
                    compare_field("refl_red", e.red, refl_red);
                    compare_field("refl_green", e.green, refl_green);
                    compare_field("refl_blue", e.blue, refl_blue);
                    compare_field("direct_pdf", e.fwd, direct_pdf);
                    compare_field("reverse_pdf", e.rev, reverse_pdf);
                end
            end
            if (cfg_valid && cfg_ready)
                grazing_thr <= cfg_data;
        end
        pending = shade_q.size();
    end
endmodule

// ----- tb/sv/tb.sv -----
// Testbench top that drives shading queries into the BRDF evaluator and gives the verdict.
`timescale 1ns / 100ps
module tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] out_dir_x = '0, out_dir_y = '0, out_dir_z = '0;
    logic [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
    logic [15:0] roughness = '0, color_red = '0, color_green = '0, color_blue = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        valid_res;
    logic [15:0] refl_red, refl_green, refl_blue, direct_pdf, reverse_pdf;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          long_hold = 1'b0;
    bit          hold_done = 1'b0;

    always #5 clk = ~clk;

    rough_diffuse_brdf_eval dut (.*);
    rdbe_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // The receiver stalls at random, with one long hold-off to fill the pipeline.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (long_hold && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (120) @(posedge clk);
                hold_done = 1'b1;
            end
            n = $urandom_range(0, 99);
            if (n < 40)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                out_stall <= (n < 90) ? 1'b0 : 1'b1;
                repeat ((n < 97) ? $urandom_range(1, 3) : $urandom_range(10, 40))
                    @(posedge clk);
            end
        end
    end

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'(32768 + $urandom_range(1, 32767));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_query(logic [15:0] ox, oy, oz, ix, iy, iz, r, cr, cg, cb);
        out_dir_x <= ox; out_dir_y <= oy; out_dir_z <= oz;
        in_dir_x <= ix; in_dir_y <= iy; in_dir_z <= iz;
        roughness <= r; color_red <= cr; color_green <= cg; color_blue <= cb;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic send_random(logic [14:0] thr);
        int sel;
        logic [15:0] oz, iz;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            oz = 16'($urandom_range(thr + 1, 32767));
            iz = 16'(-$signed({1'b0, 15'($urandom_range(thr + 1, 32767))}));
            if (sel == 0)
                iz = 16'h8000;
        end
        else if (sel == 7)
        begin
            oz = 16'(thr);
            iz = 16'($urandom);
        end
        else
        begin
            oz = 16'($urandom);
            iz = 16'($urandom);
        end
        send_query(16'($urandom), 16'($urandom), oz, 16'($urandom), 16'($urandom), iz,
                   pick_q15(), pick_q15(), pick_q15(), pick_q15());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic write_threshold(logic [14:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [14:0] thr_set [5] = '{15'd0, 15'd32767, 15'd33, 15'd16000, 15'd1};
        logic [14:0] thr;
        int          per_phase [5] = '{250, 40, 300, 250, 260};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: extremes of every field, grazing limits and full-scale values.
        send_query(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h8000,
                   16'd0, 16'd32768, 16'd32768, 16'd32768);
        send_query(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h8001,
                   16'd32768, 16'd32768, 16'd0, 16'd16384);
        send_query(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                   16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_query(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
                   16'd32768, 16'd100, 16'd200, 16'd300);
        send_query(16'h0000, 16'h0000, 16'd33, 16'h0000, 16'h0000, 16'hc000,
                   16'd1000, 16'd32768, 16'd32768, 16'd32768);
        send_query(16'h0000, 16'h0000, 16'd34, 16'h0000, 16'h0000, 16'hffdf,
                   16'd1000, 16'd32768, 16'd32768, 16'd32768);
        send_query(16'h0000, 16'h0000, 16'd34, 16'h0000, 16'h0000, 16'hffde,
                   16'd20000, 16'd32768, 16'd32768, 16'd32768);
        send_query(16'h4000, 16'h0000, 16'h6000, 16'h4000, 16'h0000, 16'ha000,
                   16'd32768, 16'd32768, 16'd32768, 16'd32768);
        send_query(16'hc000, 16'h0000, 16'h6000, 16'h4000, 16'h0000, 16'ha000,
                   16'd32768, 16'd32768, 16'd32768, 16'd32768);
        send_query(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h7fff,
                   16'd5000, 16'd5000, 16'd5000, 16'd5000);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            thr = thr_set[p];
            write_threshold(thr);
            if (p == 2)
                long_hold = 1'b1;
            for (int i = 0; i < per_phase[p]; i++)
                send_random(thr);
            drain();
        end

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
